// ----- hw/rtl/olis_pkg.sv -----
// Package for the ordered list unit: operation and status codes, beat types.
package olis_pkg;

  localparam int unsigned DefaultListDepth = 16;
  localparam int unsigned ValueWidth       = 32;
  localparam int unsigned OccWidth         = 5;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                         mode;
    logic signed [ValueWidth-1:0]  item_value;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic [OccWidth-1:0]   occupancy;
  } out_t;

endpackage

// ----- hw/rtl/olis_cell.sv -----
// One list entry: holds a value, matches against the broadcast value, shifts on delete.
module olis_cell import olis_pkg::*; #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned COUNT_W = 5
) (
  input  logic                          clk_i,
  input  logic                          fire_i,
  input  mode_e                         mode_i,
  input  logic signed [ValueWidth-1:0]  value_i,
  input  logic [COUNT_W-1:0]            count_i,
  input  logic                          hit_i,
  input  logic signed [ValueWidth-1:0]  next_val_i,
  output logic                          hit_o,
  output logic signed [ValueWidth-1:0]  val_o
);

  localparam logic [COUNT_W-1:0] IdxC = COUNT_W'(IDX);

  logic signed [ValueWidth-1:0] val_q, val_d;
  logic                         occ;

  assign occ   = count_i > IdxC;
  assign hit_o = hit_i | (occ & (val_q == value_i));
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (fire_i) begin
      unique case (mode_i)
        MODE_INSERT: if (count_i == IdxC) val_d = value_i;
        MODE_DELETE: if (hit_o) val_d = next_val_i;
        MODE_SEARCH,
        MODE_CLEAR:  val_d = val_q;
        default:     val_d = val_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ----- hw/rtl/ordered_list_insert_delete_search_unit.sv -----
// Ordered list unit: a chain of entry cells with a shared count and a result register.
// An accepted input beat gives its result beat in the next cycle.
// Throughput: one operation per cycle while no result is stalled; the match chain settles each cycle.
// A new beat is taken while a result waits unless that result is stalled.
// Reset clears the entry count and the result valid; entry values are not reset.
module ordered_list_insert_delete_search_unit import olis_pkg::*; #(
  parameter int unsigned LIST_DEPTH = DefaultListDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned CountW = $clog2(LIST_DEPTH + 1);
  localparam logic [CountW-1:0] DepthC = CountW'(LIST_DEPTH);

  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_data_q, out_data_d;
  logic              fire;
  logic              found;
  logic [LIST_DEPTH:0] hit;
  logic signed [ValueWidth-1:0] vals [LIST_DEPTH];

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign fire        = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign hit[0]      = 1'b0;
  assign found       = hit[LIST_DEPTH];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [ValueWidth-1:0] next_val;
    if (i == LIST_DEPTH - 1) begin : g_last
      assign next_val = vals[i];
    end else begin : g_mid
      assign next_val = vals[i+1];
    end
    olis_cell #(
      .IDX     (i),
      .COUNT_W (CountW)
    ) u_cell (
      .clk_i      (clk_i),
      .fire_i     (fire),
      .mode_i     (in_data_i.mode),
      .value_i    (in_data_i.item_value),
      .count_i    (count_q),
      .hit_i      (hit[i]),
      .next_val_i (next_val),
      .hit_o      (hit[i+1]),
      .val_o      (vals[i])
    );
  end

  always_comb begin
    status_e st;
    st          = STATUS_DONE;
    count_d     = count_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    if (fire) begin
      unique case (in_data_i.mode)
        MODE_INSERT: begin
          if (count_q >= DepthC) st = STATUS_FULL;
          else count_d = count_q + CountW'(1);
        end
        MODE_DELETE: begin
          if (!found) st = STATUS_MISSING;
          else count_d = count_q - CountW'(1);
        end
        MODE_SEARCH: if (!found) st = STATUS_MISSING;
        MODE_CLEAR:  count_d = '0;
        default:     st = STATUS_DONE;
      endcase
      out_valid_d          = 1'b1;
      out_data_d.status    = st;
      out_data_d.occupancy = OccWidth'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

// ----- hw/rtl/olis_checker.sv -----
// Port-level checks for the ordered list unit, bound to the top level.
module olis_checker import olis_pkg::*; #(
  parameter int unsigned LIST_DEPTH = DefaultListDepth
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat gave no result beat");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.mode == MODE_CLEAR |=>
      out_data_o.status == STATUS_DONE && out_data_o.occupancy == '0)
    else $error("clear did not empty the list");

  a_full_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_FULL |->
      out_data_o.occupancy == OccWidth'(LIST_DEPTH))
    else $error("full status below depth");

endmodule

bind ordered_list_insert_delete_search_unit olis_checker #(
  .LIST_DEPTH (LIST_DEPTH)
) u_olis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
